[src/lrts_pkg.sv]
// Shared types and constants for the linear-to-tiled RGBA8 swizzle core.
// Holds the frame and tile geometry, field widths and the pipeline stage payloads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrts_pkg;

  // Frame and tile geometry
  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned TILE_W       = 160;
  localparam int unsigned TILE_H       = 120;

  // Block layout: 4x4 pixels, 64 bytes, two 32-byte planes
  localparam int unsigned BLOCK_SIDE  = 4;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned PLANE_BYTES = 32;
  localparam int unsigned BLK_SH      = $clog2(BLOCK_SIDE);
  localparam int unsigned BLKB_SH     = $clog2(BLOCK_BYTES);
  localparam int unsigned POFF_W      = 2 * BLK_SH + 1;

  // Field widths
  localparam int unsigned X_W     = 10;
  localparam int unsigned Y_W     = 9;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ADDR_W  = 21;
  localparam int unsigned PAIR_W  = 2 * COLOR_W;

  // Derived geometry
  localparam int unsigned TILES_PER_ROW  = FRAME_WIDTH / TILE_W;
  localparam int unsigned BLOCKS_PER_ROW = TILE_W / BLOCK_SIDE;
  localparam int unsigned TILE_STRIDE    = TILE_W * TILE_H * 4;

  // Reciprocals for the quotient estimate: q = (v * RECIP) >> width
  localparam logic [X_W:0] RECIP_X = (X_W + 1)'((1 << X_W) / TILE_W);
  localparam logic [Y_W:0] RECIP_Y = (Y_W + 1)'((1 << Y_W) / TILE_H);

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = X_W + Y_W + 4 * COLOR_W;
  localparam int unsigned OUT_FIELDS_W = 2 * ADDR_W + 2 * PAIR_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input pixel after unpacking
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [PAIR_W-1:0] ar;
    logic [PAIR_W-1:0] gb;
  } pix_t;

  // After quotient estimate
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [X_W-1:0]    xq;
    logic [Y_W-1:0]    yq;
    logic [PAIR_W-1:0] ar;
    logic [PAIR_W-1:0] gb;
  } est_t;

  // After quotient correction: tile coordinates and position inside the tile
  typedef struct packed {
    logic [X_W-1:0]    col;
    logic [Y_W-1:0]    row;
    logic [X_W-1:0]    lx;
    logic [Y_W-1:0]    ly;
    logic [PAIR_W-1:0] ar;
    logic [PAIR_W-1:0] gb;
  } loc_t;

  // Tile and block indexes
  typedef struct packed {
    logic [ADDR_W-1:0] tile_idx;
    logic [ADDR_W-1:0] blk_idx;
    logic [POFF_W-1:0] poff;
    logic [PAIR_W-1:0] ar;
    logic [PAIR_W-1:0] gb;
  } idx_t;

  // Final result
  typedef struct packed {
    logic [PAIR_W-1:0] gb_pair;
    logic [ADDR_W-1:0] gb_address;
    logic [PAIR_W-1:0] ar_pair;
    logic [ADDR_W-1:0] ar_address;
  } res_t;

endpackage

`default_nettype wire

[src/lrts_quot_est.sv]
// Stage 1: estimates the tile column and row by reciprocal multiplication.
// Depends on lrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrts_quot_est (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lrts_pkg::pix_t   in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output lrts_pkg::est_t   out_data_o
);
  import lrts_pkg::*;

  logic                 valid_q;
  est_t                 data_q;
  est_t                 data_d;
  logic [2*X_W:0]       xprod;
  logic [2*Y_W:0]       yprod;

  // Accept when empty or when the next stage takes the held request
  assign in_ready_o = !valid_q || out_ready_i;

  // Multiply by the scaled reciprocal; the estimate is low by at most one
  always_comb begin
    xprod = (2 * X_W + 1)'(in_data_i.x) * (2 * X_W + 1)'(RECIP_X);
    yprod = (2 * Y_W + 1)'(in_data_i.y) * (2 * Y_W + 1)'(RECIP_Y);
    data_d.x  = in_data_i.x;
    data_d.y  = in_data_i.y;
    data_d.xq = xprod[2*X_W-1:X_W];
    data_d.yq = yprod[2*Y_W-1:Y_W];
    data_d.ar = in_data_i.ar;
    data_d.gb = in_data_i.gb;
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[src/lrts_quot_fix.sv]
// Stage 2: corrects the quotient estimate and forms the position inside the tile.
// Depends on lrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrts_quot_fix (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lrts_pkg::est_t   in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output lrts_pkg::loc_t   out_data_o
);
  import lrts_pkg::*;

  logic           valid_q;
  loc_t           data_q;
  loc_t           data_d;
  logic [2*X_W:0] xback;
  logic [2*Y_W:0] yback;
  logic [X_W-1:0] xrem;
  logic [Y_W-1:0] yrem;

  assign in_ready_o = !valid_q || out_ready_i;

  // Remainder from the estimate; one conditional subtract finishes the division
  always_comb begin
    xback = (2 * X_W + 1)'(in_data_i.xq) * (2 * X_W + 1)'(TILE_W);
    yback = (2 * Y_W + 1)'(in_data_i.yq) * (2 * Y_W + 1)'(TILE_H);
    xrem  = in_data_i.x - xback[X_W-1:0];
    yrem  = in_data_i.y - yback[Y_W-1:0];
    data_d.ar = in_data_i.ar;
    data_d.gb = in_data_i.gb;
    if (int'(xrem) >= TILE_W) begin
      data_d.col = in_data_i.xq + X_W'(1);
      data_d.lx  = xrem - X_W'(TILE_W);
    end else begin
      data_d.col = in_data_i.xq;
      data_d.lx  = xrem;
    end
    if (int'(yrem) >= TILE_H) begin
      data_d.row = in_data_i.yq + Y_W'(1);
      data_d.ly  = yrem - Y_W'(TILE_H);
    end else begin
      data_d.row = in_data_i.yq;
      data_d.ly  = yrem;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[src/lrts_index.sv]
// Stage 3: computes the tile index, block index and offset within a block plane.
// Depends on lrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrts_index (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lrts_pkg::loc_t   in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output lrts_pkg::idx_t   out_data_o
);
  import lrts_pkg::*;

  logic valid_q;
  idx_t data_q;
  idx_t data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // Raster order of tiles in the frame and of blocks in the tile
  always_comb begin
    data_d.tile_idx = ADDR_W'(in_data_i.row) * ADDR_W'(TILES_PER_ROW)
                    + ADDR_W'(in_data_i.col);
    data_d.blk_idx  = ADDR_W'(in_data_i.ly >> BLK_SH) * ADDR_W'(BLOCKS_PER_ROW)
                    + ADDR_W'(in_data_i.lx >> BLK_SH);
    data_d.poff     = {in_data_i.ly[BLK_SH-1:0], in_data_i.lx[BLK_SH-1:0], 1'b0};
    data_d.ar       = in_data_i.ar;
    data_d.gb       = in_data_i.gb;
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[src/lrts_addr.sv]
// Stage 4: scales the indexes to byte addresses and holds the output result.
// Depends on lrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrts_addr (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lrts_pkg::idx_t   in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output lrts_pkg::res_t   out_data_o
);
  import lrts_pkg::*;

  logic              valid_q;
  res_t              data_q;
  res_t              data_d;
  logic [ADDR_W-1:0] ar_addr;

  assign in_ready_o = !valid_q || out_ready_i;

  // Tile base plus block base plus plane offset, wrapped to the address width
  always_comb begin
    ar_addr = in_data_i.tile_idx * ADDR_W'(TILE_STRIDE)
            + (in_data_i.blk_idx << BLKB_SH)
            + ADDR_W'(in_data_i.poff);
    data_d.ar_address = ar_addr;
    data_d.ar_pair    = in_data_i.ar;
    data_d.gb_address = ar_addr + ADDR_W'(PLANE_BYTES);
    data_d.gb_pair    = in_data_i.gb;
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[src/linear_to_rgba8_tile_swizzle_core.sv]
// Top level of the linear-to-tiled RGBA8 swizzle core.
// Depends on lrts_pkg, lrts_quot_est, lrts_quot_fix, lrts_index and lrts_addr.
`timescale 1ns / 1ps
`default_nettype none

// Converts one linear-frame RGBA pixel into the byte addresses and 16-bit contents
// of its alpha/red and green/blue halves in a tiled RGBA8 store (160x120 tiles,
// 4x4-pixel blocks of 64 bytes, green/blue pairs 32 bytes after alpha/red pairs).
// The core takes one pixel per clock while the output is not held off and passes
// each request through a four-register pipeline: quotient estimate, quotient
// correction, index formation, address scaling. Each stage holds one request and
// takes a new one when it is empty or its successor takes the one it holds, so
// bubbles close up under back-pressure and nothing is dropped or repeated.
// Coordinates outside the frame are mapped by the same formula and the addresses
// wrap to 21 bits.

module linear_to_rgba8_tile_swizzle_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // pixel_x[9:0], pixel_y[18:10], red[26:19], green[34:27], blue[42:35],
  // alpha[50:43], zero pad[55:51]
  input  wire  [lrts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // ar_address[20:0], ar_pair[36:21], gb_address[57:37], gb_pair[73:58],
  // zero pad[79:74]
  output logic [lrts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import lrts_pkg::*;

  pix_t pix;
  est_t est;
  loc_t loc;
  idx_t idx;
  res_t res;
  logic est_valid, est_ready;
  logic loc_valid, loc_ready;
  logic idx_valid, idx_ready;
  logic [COLOR_W-1:0] red, green, blue, alpha;

  // Unpack the request and pair the color bytes
  always_comb begin
    red    = s_axis_tdata[X_W+Y_W +: COLOR_W];
    green  = s_axis_tdata[X_W+Y_W+COLOR_W +: COLOR_W];
    blue   = s_axis_tdata[X_W+Y_W+2*COLOR_W +: COLOR_W];
    alpha  = s_axis_tdata[X_W+Y_W+3*COLOR_W +: COLOR_W];
    pix.x  = s_axis_tdata[0 +: X_W];
    pix.y  = s_axis_tdata[X_W +: Y_W];
    pix.ar = {alpha, red};
    pix.gb = {green, blue};
  end

  lrts_quot_est u_quot_est (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (pix),
    .out_valid_o (est_valid),
    .out_ready_i (est_ready),
    .out_data_o  (est)
  );

  lrts_quot_fix u_quot_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (est_valid),
    .in_ready_o  (est_ready),
    .in_data_i   (est),
    .out_valid_o (loc_valid),
    .out_ready_i (loc_ready),
    .out_data_o  (loc)
  );

  lrts_index u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (loc_valid),
    .in_ready_o  (loc_ready),
    .in_data_i   (loc),
    .out_valid_o (idx_valid),
    .out_ready_i (idx_ready),
    .out_data_o  (idx)
  );

  lrts_addr u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (idx_valid),
    .in_ready_o  (idx_ready),
    .in_data_i   (idx),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack the result, zero pad on top
  assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule

`default_nettype wire

[src/lrts_checker.sv]
// Port-level checker for the swizzle core, bound to the top level.
// Depends on lrts_pkg and linear_to_rgba8_tile_swizzle_core.
`timescale 1ns / 1ps
`default_nettype none

module lrts_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire [lrts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [lrts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import lrts_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Keep the green/blue pair one plane after the alpha/red pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*ADDR_W+PAIR_W-1:ADDR_W+PAIR_W]
                      == m_axis_tdata[ADDR_W-1:0] + ADDR_W'(PLANE_BYTES))
    else $error("gb_address is not ar_address plus one plane");

  // Align the alpha/red pair address to two bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[0])
    else $error("odd ar_address");

  // Accept requests whenever no result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

endmodule

bind linear_to_rgba8_tile_swizzle_core lrts_checker u_lrts_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for linear_to_rgba8_tile_swizzle_core.
// Drives pixels on the input stream and checks each tiled address/data result against
// an in-bench swizzle predictor. Depends on lrts_pkg and the core's RTL.
`timescale 1ns / 1ps

module testbench;
  import lrts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // One linear-frame pixel as offered on the input stream
  typedef struct {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // pixel_x, pixel_y, red, green, blue, alpha, zero pad (lowest bit first)
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // ar_address, ar_pair, gb_address, gb_pair, zero pad (lowest bit first)
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Expected tiled writes, oldest first
  res_t        pending_writes[$];
  int unsigned pixels_sent;
  int unsigned writes_checked;
  int unsigned outside_pixels;
  int unsigned input_stall_cycles;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;

  linear_to_rgba8_tile_swizzle_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tiled store layout: tiles in raster order, 4x4 blocks of 64 bytes inside a tile,
  // alpha/red plane in the first 32 bytes of a block, green/blue plane in the last 32
  function automatic res_t swizzle_pixel(pixel_t px);
    longint unsigned col, row, lx, ly, tile_no, block_no, pair_off, base;
    res_t            wr;
    col      = px.x;
    row      = px.y;
    tile_no  = (row / TILE_H) * (FRAME_WIDTH / TILE_W) + col / TILE_W;
    lx       = col % TILE_W;
    ly       = row % TILE_H;
    block_no = (ly / BLOCK_SIDE) * (TILE_W / BLOCK_SIDE) + lx / BLOCK_SIDE;
    pair_off = ((ly % BLOCK_SIDE) * BLOCK_SIDE + lx % BLOCK_SIDE) * 2;
    base     = tile_no * TILE_W * TILE_H * 4 + block_no * BLOCK_BYTES + pair_off;
    wr.ar_address = base[ADDR_W-1:0];
    wr.ar_pair    = {px.alpha, px.red};
    base          = base + PLANE_BYTES;
    wr.gb_address = base[ADDR_W-1:0];
    wr.gb_pair    = {px.green, px.blue};
    return wr;
  endfunction

  function automatic pixel_t make_pixel(int unsigned x, int unsigned y, int unsigned r,
                                        int unsigned g, int unsigned b, int unsigned a);
    pixel_t px;
    px.x     = x[X_W-1:0];
    px.y     = y[Y_W-1:0];
    px.red   = r[COLOR_W-1:0];
    px.green = g[COLOR_W-1:0];
    px.blue  = b[COLOR_W-1:0];
    px.alpha = a[COLOR_W-1:0];
    return px;
  endfunction

  // Mostly in-frame pixels; the rest fall outside the frame in x, y or both
  function automatic pixel_t random_pixel(bit outside);
    int unsigned x, y, sel;
    x = $urandom_range(0, FRAME_WIDTH - 1);
    y = $urandom_range(0, FRAME_HEIGHT - 1);
    if (outside) begin
      sel = $urandom_range(0, 2);
      if (sel != 1) x = $urandom_range(FRAME_WIDTH, (1 << X_W) - 1);
      if (sel != 0) y = $urandom_range(FRAME_HEIGHT, (1 << Y_W) - 1);
    end
    return make_pixel(x, y, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Offer one pixel, optionally after an idle burst, and hold it until accepted
  task automatic send_pixel(pixel_t px);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                      px.alpha, px.blue, px.green, px.red, px.y, px.x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_writes.push_back(swizzle_pixel(px));
    pixels_sent++;
    if (px.x >= FRAME_WIDTH || px.y >= FRAME_HEIGHT) outside_pixels++;
  endtask

  // Drop the input request and wait for every expected write
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready bursts, or a long hold when a test asks for one
  initial begin
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest expected write
  task automatic check_write(res_t got);
    res_t want;
    if (pending_writes.size() == 0) begin
      $error("unexpected result: ar_address %0d", got.ar_address);
      mismatch_count++;
      return;
    end
    want = pending_writes.pop_front();
    writes_checked++;
    if (got.ar_address !== want.ar_address) begin
      $error("ar_address: expected %0d, got %0d", want.ar_address, got.ar_address);
      mismatch_count++;
    end
    if (got.ar_pair !== want.ar_pair) begin
      $error("ar_pair: expected %h, got %h", want.ar_pair, got.ar_pair);
      mismatch_count++;
    end
    if (got.gb_address !== want.gb_address) begin
      $error("gb_address: expected %0d, got %0d", want.gb_address, got.gb_address);
      mismatch_count++;
    end
    if (got.gb_pair !== want.gb_pair) begin
      $error("gb_pair: expected %h, got %h", want.gb_pair, got.gb_pair);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_write(res_t'(m_axis_tdata[OUT_FIELDS_W-1:0]));
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Frame corners, tile and block edges, coordinates past the frame, color extremes
  task automatic test_corners();
    pixel_t corners[$];
    corners = '{
      make_pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'h00),
      make_pixel(639, 479, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
      make_pixel(3, 3, 8'hAA, 8'h55, 8'hAA, 8'h55),
      make_pixel(4, 4, 8'h55, 8'hAA, 8'h55, 8'hAA),
      make_pixel(159, 119, 8'h01, 8'h80, 8'h7F, 8'hFE),
      make_pixel(160, 0, 8'h80, 8'h01, 8'hFE, 8'h7F),
      make_pixel(0, 120, 8'h12, 8'h34, 8'h56, 8'h78),
      make_pixel(160, 120, 8'hFF, 8'h00, 8'hFF, 8'h00),
      make_pixel(480, 360, 8'h00, 8'hFF, 8'h00, 8'hFF),
      make_pixel(479, 359, 8'hC3, 8'h3C, 8'h96, 8'h69),
      make_pixel(638, 1, 8'h0F, 8'hF0, 8'h0F, 8'hF0),
      make_pixel(640, 0, 8'h11, 8'h22, 8'h33, 8'h44),
      make_pixel(0, 480, 8'h55, 8'h66, 8'h77, 8'h88),
      make_pixel(1023, 0, 8'h99, 8'hAA, 8'hBB, 8'hCC),
      make_pixel(0, 511, 8'hDD, 8'hEE, 8'hFF, 8'h00),
      make_pixel(1023, 511, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
      make_pixel(800, 500, 8'hA5, 8'h5A, 8'hA5, 8'h5A),
      make_pixel(512, 256, 8'h00, 8'h00, 8'h00, 8'h00)
    };
    foreach (corners[i]) send_pixel(corners[i]);
    drain_writes();
  endtask

  // Raster-scan an 8x8 patch that straddles a tile corner
  task automatic test_tile_corner_scan(int unsigned passes);
    int unsigned x0, y0;
    repeat (passes) begin
      x0 = TILE_W * $urandom_range(1, TILES_PER_ROW - 1) - 4;
      y0 = TILE_H * $urandom_range(1, FRAME_HEIGHT / TILE_H - 1) - 4;
      for (int unsigned dy = 0; dy < 8; dy++)
        for (int unsigned dx = 0; dx < 8; dx++)
          send_pixel(make_pixel(x0 + dx, y0 + dy, $urandom, $urandom, $urandom, $urandom));
    end
    drain_writes();
  endtask

  task automatic test_random_pixels(int unsigned count);
    repeat (count) send_pixel(random_pixel($urandom_range(0, 9) == 0));
    drain_writes();
  endtask

  // Hold the receiver off while pixels keep coming, so the pipeline fills and stalls
  task automatic test_output_backpressure(int unsigned count);
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 150;
    repeat (count) send_pixel(random_pixel($urandom_range(0, 4) == 0));
    drain_writes();
    tx_idle_en = 1'b1;
  endtask

  // Full-rate streaming with no idling on either side
  task automatic test_full_rate(int unsigned count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_pixel(random_pixel($urandom_range(0, 9) == 0));
    drain_writes();
  endtask

  initial begin
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    test_tile_corner_scan(2);
    test_random_pixels(850);
    test_output_backpressure(60);
    test_full_rate(100);

    repeat (10) @(posedge clk_i);
    $display("Swizzled %0d pixels (%0d outside the frame), checked %0d tiled writes,",
             pixels_sent, outside_pixels, writes_checked);
    $display("input held off for %0d cycles by output back-pressure.", input_stall_cycles);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
